### rtl/stq_pkg.sv
// stq_pkg: shared constants, codes, command/status types and helpers for the
// sparse table range query block. No dependencies; used by every rtl/ file.
`default_nettype none

package stq_pkg;

    // default parameter values
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VALUE_WIDTH_DEF  = 32;

    // stream field widths
    localparam int VALUE_W    = 32;
    localparam int IN_IDX_W   = 10;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    // query length and its log
    localparam int LEN_W = IN_IDX_W + 1;
    localparam int LOG_W = 4;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int OP_W   = 2;

    // register word indexes
    localparam logic REG_OP_MODE = 1'b0;

    // item kinds carried in tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // combining operations, any other code acts as minimum
    localparam logic [OP_W-1:0] OP_MIN = 2'd0;
    localparam logic [OP_W-1:0] OP_MAX = 2'd1;
    localparam logic [OP_W-1:0] OP_GCD = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BCHK,
        ST_BRD,
        ST_BSTART,
        ST_BWAIT,
        ST_QPREP,
        ST_QRD,
        ST_QSTART,
        ST_QWAIT,
        ST_QOUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_CHECK,
        CS_DIV,
        CS_FIX
    } comb_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic load_wr;
        logic build_init;
        logic set_ready;
        logic build_rd;
        logic build_wr;
        logic q_prep;
        logic q_rd;
        logic comb_start;
        logic out_load;
    } stq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_flag;
        logic span_fits;
        logic i_last;
        logic q_valid;
        logic comb_done;
        logic comb_busy;
        logic out_free;
    } stq_sts_t;

    // index of the highest set bit, zero for zero
    function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] x);
        logic [LOG_W-1:0] k;
        k = '0;
        for (int b = 1; b < LEN_W; b++) begin
            if (x[b]) begin
                k = LOG_W'(b);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/stq_comb.sv
// stq_comb: combining unit for two table values: min and max as a registered
// compare, gcd as Euclid over a bit-serial truncating remainder. Depends on stq_pkg.
`default_nettype none

module stq_comb #(
    parameter int VALUE_WIDTH = stq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [stq_pkg::OP_W-1:0]      op,
    input  wire logic signed [VALUE_WIDTH-1:0] a,
    input  wire logic signed [VALUE_WIDTH-1:0] b,
    output logic                               done,
    output logic                               busy,
    output logic signed [VALUE_WIDTH-1:0]      result
);

    localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

    stq_pkg::comb_state_t state_reg, state_next;

    logic signed [VALUE_WIDTH-1:0] x_reg, y_reg, result_reg;
    logic [VALUE_WIDTH-1:0]        dvd_reg, dsr_reg, rem_reg;
    logic [STEP_W-1:0]             cnt_reg;
    logic                          neg_reg, done_reg;

    logic [VALUE_WIDTH-1:0] x_mag, y_mag, rem_sh, rem_next;
    logic                   rem_ge;

    // magnitudes, the most negative value maps onto its unsigned magnitude
    assign x_mag = x_reg[VALUE_WIDTH-1] ? VALUE_WIDTH'(-x_reg) : VALUE_WIDTH'(x_reg);
    assign y_mag = y_reg[VALUE_WIDTH-1] ? VALUE_WIDTH'(-y_reg) : VALUE_WIDTH'(y_reg);

    // one restoring step of the remainder
    assign rem_sh   = {rem_reg[VALUE_WIDTH-2:0], dvd_reg[VALUE_WIDTH-1]};
    assign rem_ge   = (rem_sh >= dsr_reg);
    assign rem_next = rem_ge ? (rem_sh - dsr_reg) : rem_sh;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::CS_IDLE: begin
                if (start && (op == stq_pkg::OP_GCD)) begin
                    state_next = stq_pkg::CS_CHECK;
                end
            end
            stq_pkg::CS_CHECK: begin
                state_next = (y_reg != '0) ? stq_pkg::CS_DIV : stq_pkg::CS_IDLE;
            end
            stq_pkg::CS_DIV: begin
                if (cnt_reg == STEP_W'(1)) begin
                    state_next = stq_pkg::CS_FIX;
                end
            end
            stq_pkg::CS_FIX: begin
                state_next = stq_pkg::CS_CHECK;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy   = (state_reg != stq_pkg::CS_IDLE);
        done   = done_reg;
        result = result_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stq_pkg::CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == stq_pkg::CS_IDLE) && start
                          && (op != stq_pkg::OP_GCD))
                         || ((state_reg == stq_pkg::CS_CHECK) && (y_reg == '0));
        end
    end

    // operand and remainder registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            stq_pkg::CS_IDLE: begin
                if (start) begin
                    x_reg <= a;
                    y_reg <= b;
                    if (op == stq_pkg::OP_MAX) begin
                        result_reg <= (a > b) ? a : b;
                    end else begin
                        result_reg <= (a < b) ? a : b;
                    end
                end
            end
            stq_pkg::CS_CHECK: begin
                result_reg <= x_reg;
                dvd_reg    <= x_mag;
                dsr_reg    <= y_mag;
                rem_reg    <= '0;
                neg_reg    <= x_reg[VALUE_WIDTH-1];
                cnt_reg    <= STEP_W'(VALUE_WIDTH);
            end
            stq_pkg::CS_DIV: begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - STEP_W'(1);
            end
            stq_pkg::CS_FIX: begin
                // remainder takes the sign of the dividend
                x_reg <= y_reg;
                y_reg <= neg_reg ? (VALUE_WIDTH'(0) - rem_reg) : rem_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/stq_dp.sv
// stq_dp: datapath of the sparse table block: item capture, element count,
// level memory, build and query address logic, output register.
// Depends on stq_pkg and stq_comb.
`default_nettype none

module stq_dp #(
    parameter int MAX_ELEMENTS = stq_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = stq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire stq_pkg::stq_cmd_t               cmd,
    output stq_pkg::stq_sts_t                    sts,
    input  wire logic                            s_tvalid,
    input  wire logic [stq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tlast,
    input  wire logic [stq_pkg::OP_W-1:0]        op_mode,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [stq_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tuser
);

    localparam int IDX_W     = $clog2(MAX_ELEMENTS);
    localparam int LEVELS    = IDX_W + 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
    localparam int SPAN_W    = CNT_W + 1;
    localparam int AW        = LVL_W + IDX_W;
    localparam int MEM_DEPTH = LEVELS * (2 ** IDX_W);
    localparam int CMP_W     = CNT_W + stq_pkg::IN_IDX_W;
    localparam int LEN_W     = stq_pkg::LEN_W;

    // captured item
    logic [stq_pkg::VALUE_W-1:0]  value_reg;
    logic                         last_reg;
    logic [stq_pkg::IN_IDX_W-1:0] left_reg, right_reg;

    // array and build state
    logic [CNT_W-1:0]         count_reg;
    logic                     ready_reg;
    logic [stq_pkg::OP_W-1:0] built_op_reg;
    logic [LVL_W-1:0]         k_reg;
    logic [SPAN_W-1:0]        span_reg;
    logic [IDX_W-1:0]         i_reg;

    // query state
    logic [LVL_W-1:0] qk_reg;
    logic [IDX_W-1:0] qj_reg;
    logic             q_valid_reg;

    // level memory, undefined until written
    logic [VALUE_WIDTH-1:0]        level_mem [MEM_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rd_a_reg, rd_b_reg;

    // output register
    logic                         m_valid_reg;
    logic [stq_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                         m_user_reg;

    logic                          wr_en, rd_en;
    logic [AW-1:0]                 wr_addr, rd_a_addr, rd_b_addr;
    logic [VALUE_WIDTH-1:0]        wr_data;
    logic [63:0]                   val_ext, res_ext;
    logic [SPAN_W-1:0]             half, i_span, i_half;
    logic                          span_fits, i_last, count_room;
    logic [LEN_W-1:0]              q_len, q_j;
    logic [stq_pkg::LOG_W-1:0]     q_log;
    logic                          q_ok;
    logic                          comb_done, comb_busy;
    logic signed [VALUE_WIDTH-1:0] comb_result;

    // element value wrapped to the stored width
    assign val_ext = 64'(signed'(value_reg));
    assign res_ext = 64'(comb_result);

    // build loop bounds
    assign half       = span_reg >> 1;
    assign i_span     = SPAN_W'(i_reg) + span_reg;
    assign i_half     = SPAN_W'(i_reg) + half;
    assign span_fits  = (span_reg <= SPAN_W'(count_reg));
    assign i_last     = (i_span == SPAN_W'(count_reg));
    assign count_room = (count_reg < CNT_W'(MAX_ELEMENTS));

    // query window selection
    assign q_len = {1'b0, right_reg} - {1'b0, left_reg} + LEN_W'(1);
    assign q_log = stq_pkg::floor_log2(q_len);
    assign q_j   = {1'b0, right_reg} + LEN_W'(1) - (LEN_W'(1) << q_log);
    assign q_ok  = ready_reg && (left_reg <= right_reg)
                   && (CMP_W'(right_reg) < CMP_W'(count_reg));

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.take && s_tvalid) begin
            value_reg <= s_tdata[stq_pkg::VALUE_W-1:0];
            left_reg  <= s_tdata[stq_pkg::VALUE_W +: stq_pkg::IN_IDX_W];
            right_reg <= s_tdata[stq_pkg::VALUE_W + stq_pkg::IN_IDX_W +: stq_pkg::IN_IDX_W];
            last_reg  <= s_tlast;
        end
    end

    // count, ready flag and sampled operation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ready_reg    <= 1'b0;
            built_op_reg <= stq_pkg::OP_MIN;
        end else begin
            if (cmd.load_wr) begin
                if (ready_reg) begin
                    // a load after a build starts a new array
                    count_reg <= CNT_W'(1);
                    ready_reg <= 1'b0;
                end else if (count_room) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.build_init) begin
                built_op_reg <= op_mode;
            end
            if (cmd.set_ready) begin
                ready_reg <= 1'b1;
            end
        end
    end

    // build level and position
    always_ff @(posedge aclk) begin
        if (cmd.build_init) begin
            k_reg    <= LVL_W'(1);
            span_reg <= SPAN_W'(2);
            i_reg    <= '0;
        end else if (cmd.build_wr) begin
            if (i_last) begin
                k_reg    <= k_reg + LVL_W'(1);
                span_reg <= span_reg << 1;
                i_reg    <= '0;
            end else begin
                i_reg <= i_reg + IDX_W'(1);
            end
        end
    end

    // query preparation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (cmd.q_prep) begin
            q_valid_reg <= q_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.q_prep) begin
            qk_reg <= LVL_W'(q_log);
            qj_reg <= IDX_W'(q_j);
        end
    end

    // memory write port: element loads and build results
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {k_reg, i_reg};
        wr_data = comb_result;
        if (cmd.load_wr) begin
            wr_en   = ready_reg || count_room;
            wr_addr = {LVL_W'(0), (ready_reg ? IDX_W'(0) : IDX_W'(count_reg))};
            wr_data = val_ext[VALUE_WIDTH-1:0];
        end else if (cmd.build_wr) begin
            wr_en = 1'b1;
        end
    end

    // memory read ports: two windows at a time
    always_comb begin
        rd_en = cmd.build_rd || cmd.q_rd;
        if (cmd.build_rd) begin
            rd_a_addr = {k_reg - LVL_W'(1), i_reg};
            rd_b_addr = {k_reg - LVL_W'(1), IDX_W'(i_half)};
        end else begin
            rd_a_addr = {qk_reg, IDX_W'(left_reg)};
            rd_b_addr = {qk_reg, qj_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            level_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= level_mem[rd_a_addr];
            rd_b_reg <= level_mem[rd_b_addr];
        end
    end

    stq_comb #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_comb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.comb_start),
        .op      (built_op_reg),
        .a       (rd_a_reg),
        .b       (rd_b_reg),
        .done    (comb_done),
        .busy    (comb_busy),
        .result  (comb_result)
    );

    // output register, taken on its own handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= q_valid_reg ? res_ext[stq_pkg::M_TDATA_W-1:0] : '0;
            m_user_reg <= q_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // status to controller
    always_comb begin
        sts.last_flag = last_reg;
        sts.span_fits = span_fits;
        sts.i_last    = i_last;
        sts.q_valid   = q_valid_reg;
        sts.comb_done = comb_done;
        sts.comb_busy = comb_busy;
        sts.out_free  = !m_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

### rtl/stq_ctrl.sv
// stq_ctrl: controller state machine that sequences loads, table builds and
// queries through datapath commands. Depends on stq_pkg.
`default_nettype none

module stq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_beat,
    input  wire logic              in_is_query,
    input  wire stq_pkg::stq_sts_t sts,
    output stq_pkg::stq_cmd_t      cmd
);

    stq_pkg::ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::ST_IDLE: begin
                if (in_beat) begin
                    state_next = (in_is_query == stq_pkg::ACT_QUERY)
                                 ? stq_pkg::ST_QPREP : stq_pkg::ST_LOAD;
                end
            end
            stq_pkg::ST_LOAD: begin
                state_next = sts.last_flag ? stq_pkg::ST_BCHK : stq_pkg::ST_IDLE;
            end
            stq_pkg::ST_BCHK: begin
                state_next = sts.span_fits ? stq_pkg::ST_BRD : stq_pkg::ST_IDLE;
            end
            stq_pkg::ST_BRD: begin
                state_next = stq_pkg::ST_BSTART;
            end
            stq_pkg::ST_BSTART: begin
                state_next = stq_pkg::ST_BWAIT;
            end
            stq_pkg::ST_BWAIT: begin
                if (sts.comb_done) begin
                    state_next = sts.i_last ? stq_pkg::ST_BCHK : stq_pkg::ST_BRD;
                end
            end
            stq_pkg::ST_QPREP: begin
                state_next = stq_pkg::ST_QRD;
            end
            stq_pkg::ST_QRD: begin
                state_next = sts.q_valid ? stq_pkg::ST_QSTART : stq_pkg::ST_QOUT;
            end
            stq_pkg::ST_QSTART: begin
                state_next = stq_pkg::ST_QWAIT;
            end
            stq_pkg::ST_QWAIT: begin
                if (sts.comb_done) begin
                    state_next = sts.out_free ? stq_pkg::ST_IDLE : stq_pkg::ST_QOUT;
                end
            end
            stq_pkg::ST_QOUT: begin
                if (sts.out_free) begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            stq_pkg::ST_IDLE: begin
                cmd.take = 1'b1;
            end
            stq_pkg::ST_LOAD: begin
                cmd.load_wr    = 1'b1;
                cmd.build_init = sts.last_flag;
            end
            stq_pkg::ST_BCHK: begin
                cmd.set_ready = !sts.span_fits;
            end
            stq_pkg::ST_BRD: begin
                cmd.build_rd = 1'b1;
            end
            stq_pkg::ST_BSTART: begin
                cmd.comb_start = 1'b1;
            end
            stq_pkg::ST_BWAIT: begin
                cmd.build_wr = sts.comb_done;
            end
            stq_pkg::ST_QPREP: begin
                cmd.q_prep = 1'b1;
            end
            stq_pkg::ST_QRD: begin
                cmd.q_rd = sts.q_valid;
            end
            stq_pkg::ST_QSTART: begin
                cmd.comb_start = 1'b1;
            end
            stq_pkg::ST_QWAIT: begin
                cmd.out_load = sts.comb_done && sts.out_free;
            end
            stq_pkg::ST_QOUT: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sparse_table_range_query_top.sv
// Sparse table range query block. Load beats write elements into level 0; the
// load beat marked last builds the higher levels, one entry at a time through a
// single combining unit (minimum, maximum or gcd chosen by op_mode, sampled when
// the build starts). A query beat returns one result beat: the operation over
// left..right from two overlapping power-of-two windows, or zero with in_range
// low when the range is empty, past the loaded count or no table is built.
// The build walks the levels entry by entry. A query goes through the two-port
// level memory read and the registered combine to the output register, and the
// block takes no new beat until that query is done. Under gcd each combine runs
// Euclid remainder steps on the bit-serial remainder unit. The output register
// lets a load be taken while a result waits. The level memory needs no clearing
// pass after reset.
// Depends on stq_pkg, stq_ctrl, stq_dp.
`default_nettype none

module sparse_table_range_query_top #(
    parameter int MAX_ELEMENTS = stq_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = stq_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input beats
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [stq_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // value[31:0], left[41:32], right[51:42]
    input  wire logic                           s_axis_tuser,  // action
    input  wire logic                           s_axis_tlast,
    // result beats
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [stq_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // result[31:0]
    output logic                                m_axis_tuser,  // in_range
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [stq_pkg::APB_AW-1:0]     paddr,
    input  wire logic [stq_pkg::APB_DW-1:0]     pwdata,
    output logic [stq_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    stq_pkg::stq_cmd_t        cmd;
    stq_pkg::stq_sts_t        sts;
    logic [stq_pkg::OP_W-1:0] op_mode_reg;
    logic                     cfg_wr, in_beat;
    logic                     reg_idx;

    // register file: op_mode at word index 0
    assign reg_idx = paddr[stq_pkg::APB_AW-1];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg <= stq_pkg::OP_MIN;
        end else if (cfg_wr && (reg_idx == stq_pkg::REG_OP_MODE)) begin
            op_mode_reg <= pwdata[stq_pkg::OP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == stq_pkg::REG_OP_MODE) begin
            prdata = {{(stq_pkg::APB_DW - stq_pkg::OP_W){1'b0}}, op_mode_reg};
        end
    end

    // input handshake
    assign s_axis_tready = cmd.take;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    stq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_beat     (in_beat),
        .in_is_query (s_axis_tuser),
        .sts         (sts),
        .cmd         (cmd)
    );

    stq_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tvalid (s_axis_tvalid),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .op_mode  (op_mode_reg),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

    // an accepted beat always occupies the controller for the next cycle
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_axis_tready)
        else $error("input taken right after an accepted beat");

    // no new beat while the combining unit still works
    a_idle_comb: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !sts.comb_busy)
        else $error("input ready while combine unit busy");

    // a result appears only when the controller loads one
    a_out_from_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(cmd.out_load))
        else $error("result beat without a query completion");

endmodule

`default_nettype wire
